// ===== rtl/npc_pkg.sv =====
package npc_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    // only the first 256 slots can ever be written
    localparam int MAX_SCAN = 256;

    localparam int WORD_W = 32;
    localparam int COMP_W = 8;
    localparam int SQ_W   = 2 * COMP_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int PEN_W  = 8;

    localparam logic [WORD_W-1:0] UNUSED_WORD = 32'hffff_ffff;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [7:0]        entry_index;
        logic [WORD_W-1:0] entry_word;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } in_req_t;

    typedef struct packed {
        logic [PEN_W-1:0] pen;
        logic             found;
    } out_res_t;

    // travels with each palette read through the distance pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [PEN_W-1:0] idx;
    } tag_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              used;
        logic [PEN_W-1:0]  idx;
        logic [DIST_W-1:0] sq_sum;
    } dist_res_t;

endpackage

// ===== rtl/npc_ram.sv =====
module npc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/npc_dist.sv =====
module npc_dist (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              flush,
    input  logic [npc_pkg::WORD_W-1:0]        word,
    input  npc_pkg::tag_t                     tag,
    input  logic [npc_pkg::COMP_W-1:0]        red,
    input  logic [npc_pkg::COMP_W-1:0]        green,
    input  logic [npc_pkg::COMP_W-1:0]        blue,
    output npc_pkg::dist_res_t                res
);
    import npc_pkg::*;

    // stage 1: absolute differences
    tag_t              s1_tag_reg, s1_tag_next;
    logic              s1_used_reg;
    logic [COMP_W-1:0] s1_dr_reg, s1_dg_reg, s1_db_reg;
    // stage 2: squares
    tag_t              s2_tag_reg, s2_tag_next;
    logic              s2_used_reg;
    logic [SQ_W-1:0]   s2_sr_reg, s2_sg_reg, s2_sb_reg;

    function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                   input logic [COMP_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        s1_tag_next = tag;
        s2_tag_next = s1_tag_reg;
        if (flush) begin
            s1_tag_next.valid = 1'b0;
            s2_tag_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end else begin
            s1_tag_reg <= s1_tag_next;
            s2_tag_reg <= s2_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_used_reg <= (word != UNUSED_WORD);
        s1_dr_reg   <= abs_diff(word[23:16], red);
        s1_dg_reg   <= abs_diff(word[15:8], green);
        s1_db_reg   <= abs_diff(word[7:0], blue);

        s2_used_reg <= s1_used_reg;
        s2_sr_reg   <= s1_dr_reg * s1_dr_reg;
        s2_sg_reg   <= s1_dg_reg * s1_dg_reg;
        s2_sb_reg   <= s1_db_reg * s1_db_reg;
    end

    always_comb begin
        res.valid  = s2_tag_reg.valid;
        res.last   = s2_tag_reg.last;
        res.idx    = s2_tag_reg.idx;
        res.used   = s2_used_reg;
        res.sq_sum = DIST_W'(s2_sr_reg) + DIST_W'(s2_sg_reg) + DIST_W'(s2_sb_reg);
    end

endmodule

// ===== rtl/nearest_palette_color_search.sv =====
// Query: the scan reads DEPTH = min(PALETTE_ENTRIES, 256) palette words, one palette word
//   per cycle through a single RAM read port and distance pipeline; the next request is
//   taken only after the result is registered. An exact match ends the scan early.
// Write: no result; the next request can be taken in the following cycle.
// Reset (synchronous, active low) starts a clearing pass that marks every one of the DEPTH
//   palette slots unused; no request is taken until it ends.
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  npc_pkg::in_req_t  s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output npc_pkg::out_res_t m_res
);
    import npc_pkg::*;

    localparam int DEPTH = (PALETTE_ENTRIES < MAX_SCAN) ? PALETTE_ENTRIES : MAX_SCAN;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [8:0]    DEPTH_W = 9'(DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_idx_reg, clr_idx_next;
    logic [AW-1:0]     issue_idx_reg, issue_idx_next;
    logic              issue_active_reg, issue_active_next;
    tag_t              rd_tag_reg, rd_tag_next;
    logic [COMP_W-1:0] red_reg, green_reg, blue_reg;
    logic [DIST_W-1:0] best_reg, best_next;
    logic [PEN_W-1:0]  pen_reg, pen_next;
    logic              found_reg, found_next;
    logic              m_valid_reg, m_valid_next;
    out_res_t          m_res_reg, m_res_next;

    logic              accept;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic              issue;
    logic              end_scan;
    logic              better;
    dist_res_t         dres;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign issue   = (state_reg == ST_SCAN) && issue_active_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = s_req.entry_index[AW-1:0];
        ram_wdata = s_req.entry_word;
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = UNUSED_WORD;
        end else if (accept && s_req.kind == KIND_WRITE &&
                     ({1'b0, s_req.entry_index} < DEPTH_W)) begin
            ram_we = 1'b1;
        end
    end

    npc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_idx_reg),
        .rdata (ram_rdata)
    );

    npc_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flush   (end_scan),
        .word    (ram_rdata),
        .tag     (rd_tag_reg),
        .red     (red_reg),
        .green   (green_reg),
        .blue    (blue_reg),
        .res     (dres)
    );

    assign better   = dres.valid && dres.used && (!found_reg || dres.sq_sum < best_reg);
    // a zero distance cannot be beaten by any later entry
    assign end_scan = (state_reg == ST_SCAN) && dres.valid &&
                      (dres.last || (dres.used && dres.sq_sum == '0));

    always_comb begin
        state_next        = state_reg;
        clr_idx_next      = clr_idx_reg;
        issue_idx_next    = issue_idx_reg;
        issue_active_next = issue_active_reg;
        best_next         = best_reg;
        pen_next          = pen_reg;
        found_next        = found_reg;
        m_valid_next      = m_valid_reg;
        m_res_next        = m_res_reg;

        rd_tag_next.valid = issue && !end_scan;
        rd_tag_next.last  = (issue_idx_reg == LAST);
        rd_tag_next.idx   = PEN_W'(issue_idx_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && s_req.kind == KIND_QUERY) begin
                    state_next        = ST_SCAN;
                    issue_idx_next    = '0;
                    issue_active_next = 1'b1;
                    found_next        = 1'b0;
                    pen_next          = '0;
                    best_next         = '0;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                    if (issue_idx_reg == LAST) begin
                        issue_active_next = 1'b0;
                    end
                end
                if (better) begin
                    best_next  = dres.sq_sum;
                    pen_next   = dres.idx;
                    found_next = 1'b1;
                end
                if (end_scan) begin
                    issue_active_next = 1'b0;
                    state_next        = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_res_next.pen   = found_reg ? pen_reg : '0;
                    m_res_next.found = found_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            issue_active_reg <= 1'b0;
            rd_tag_reg       <= '0;
            found_reg        <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clr_idx_reg      <= clr_idx_next;
            issue_active_reg <= issue_active_next;
            rd_tag_reg       <= rd_tag_next;
            found_reg        <= found_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_idx_reg <= issue_idx_next;
        best_reg      <= best_next;
        pen_reg       <= pen_next;
        m_res_reg     <= m_res_next;
        if (accept && s_req.kind == KIND_QUERY) begin
            red_reg   <= s_req.red;
            green_reg <= s_req.green;
            blue_reg  <= s_req.blue;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    a_query_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_req.kind == KIND_QUERY) |=> (state_reg == ST_SCAN))
        else $error("query request did not start a scan");

    a_best_never_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && $past(state_reg == ST_SCAN) && $past(found_reg))
        |-> (found_reg && best_reg <= $past(best_reg)))
        else $error("best distance increased during scan");

    a_not_found_pen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_res.found) |-> (m_res.pen == '0))
        else $error("pen nonzero without a valid entry");

    a_no_issue_outside_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN) |-> !issue_active_reg || $past(state_reg == ST_IDLE))
        else $error("palette read issued outside a scan");

endmodule

// ===== sim/nearest_palette_color_search_tb.sv =====
`timescale 1ns / 100ps

module nearest_palette_color_search_tb;
    import npc_pkg::*;

    localparam int N_RANDOM       = 450;
    localparam int N_QUIET_TAIL   = 60;
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int MAX_REPORTS    = 10;

    // Shadow palette plus the queue of nearest-color answers still owed by the block.
    class palette_scoreboard;
        logic [WORD_W-1:0] palette [MAX_SCAN];
        out_res_t          pending_pens [$];
        int                mismatches;

        function new();
            foreach (palette[i]) palette[i] = UNUSED_WORD;
            mismatches = 0;
        endfunction

        function out_res_t nearest(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            out_res_t    res;
            int unsigned best;
            int unsigned sq_sum;
            int          dr;
            int          dg;
            int          db;
            bit          hit;
            res  = '0;
            best = 32'h07ff_ffff;
            hit  = 1'b0;
            for (int i = 0; i < MAX_SCAN; i++) begin
                if (palette[i] == UNUSED_WORD) continue;
                dr     = int'(palette[i][23:16]) - int'(r);
                dg     = int'(palette[i][15:8]) - int'(g);
                db     = int'(palette[i][7:0]) - int'(b);
                sq_sum = dr * dr + dg * dg + db * db;
                if (sq_sum < best || !hit) begin
                    best    = sq_sum;
                    res.pen = PEN_W'(i);
                    hit     = 1'b1;
                end
                if (sq_sum == 0) break;
            end
            res.found = hit;
            return res;
        endfunction

        function void note_request(in_req_t req);
            if (req.kind == KIND_WRITE)
                palette[req.entry_index] = req.entry_word;
            else
                pending_pens.push_back(nearest(req.red, req.green, req.blue));
        endfunction

        function void check_result(out_res_t res);
            out_res_t exp_res;
            if (pending_pens.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result pen %0d found %0d",
                             $realtime, res.pen, res.found);
                return;
            end
            exp_res = pending_pens.pop_front();
            if (res.pen !== exp_res.pen || res.found !== exp_res.found) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result pen %0d found %0d, expected pen %0d found %0d",
                             $realtime, res.pen, res.found, exp_res.pen, exp_res.found);
            end
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    in_req_t  s_req;
    logic     m_valid;
    logic     m_ready;
    out_res_t m_res;

    palette_scoreboard sb;

    bit sender_idle_on;
    bit sink_idle_on;
    bit hold_request;
    int hold_left;
    int stall_left;
    int idle_cycles;

    nearest_palette_color_search dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    always #5 aclk = ~aclk;

    // receiver: random stall bursts, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (sink_idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 18);
        end
    end

    // result is checked before the request of the same edge is noted
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_res);
        if (aresetn && s_valid && s_ready) sb.note_request(s_req);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("nearest_palette_color_search_tb: done, errors");
            $finish;
        end
    end

    function automatic in_req_t mk_write(logic [7:0] idx, logic [WORD_W-1:0] word);
        in_req_t req;
        req             = in_req_t'({1'($urandom), $urandom, $urandom});
        req.kind        = KIND_WRITE;
        req.entry_index = idx;
        req.entry_word  = word;
        return req;
    endfunction

    function automatic in_req_t mk_query(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        in_req_t req;
        req       = in_req_t'({1'($urandom), $urandom, $urandom});
        req.kind  = KIND_QUERY;
        req.red   = r;
        req.green = g;
        req.blue  = b;
        return req;
    endfunction

    function automatic in_req_t random_request();
        logic [WORD_W-1:0] col;
        logic [7:0]        idx;
        int                pick;
        col  = sb.palette[$urandom_range(0, MAX_SCAN - 1)];
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 55) begin
            // writes crowd a few low slots now and then, for overwrites and ties
            idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
                                              : 8'($urandom_range(0, 255));
            if (pick < 65)
                return mk_write(idx, {8'h00, 24'($urandom)});
            else if (pick < 77)
                return mk_write(idx, $urandom);
            else if (pick < 87)
                return mk_write(idx, UNUSED_WORD);
            else if (col != UNUSED_WORD)
                return mk_write(idx, {8'($urandom), col[23:0]});
            else
                return mk_write(idx, {8'h00, 24'($urandom)});
        end
        if (col != UNUSED_WORD && pick < 40)
            return mk_query(col[23:16], col[15:8], col[7:0]);
        if (col != UNUSED_WORD && pick < 70)
            return mk_query(col[23:16] ^ 8'($urandom_range(0, 3)),
                            col[15:8] ^ 8'($urandom_range(0, 3)),
                            col[7:0] ^ 8'($urandom_range(0, 3)));
        return mk_query(8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    task automatic send_request(input in_req_t req, input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_req   <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic int pick_gap();
        if (sender_idle_on && $urandom_range(0, 4) == 0)
            return $urandom_range(1, 18);
        return 0;
    endfunction

    initial begin
        in_req_t directed [$];
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req          = '0;
        m_ready        = 1'b0;
        sender_idle_on = 1'b1;
        sink_idle_on   = 1'b1;
        hold_request   = 1'b0;
        hold_left      = 0;
        stall_left     = 0;
        idle_cycles    = 0;
        sb             = new();

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // empty palette first, then extremes, upper-byte handling, ties and unmarking
        directed.push_back(mk_query(8'h00, 8'h00, 8'h00));
        directed.push_back(mk_query(8'hff, 8'hff, 8'hff));
        directed.push_back(mk_write(8'd255, 32'h00ff_ffff));
        directed.push_back(mk_query(8'h00, 8'h00, 8'h00));
        directed.push_back(mk_write(8'd0, 32'h0000_0000));
        directed.push_back(mk_query(8'h00, 8'h00, 8'h00));
        directed.push_back(mk_query(8'hff, 8'hff, 8'hff));
        directed.push_back(mk_query(8'h01, 8'h01, 8'h01));
        directed.push_back(mk_write(8'd10, 32'hab80_8080));
        directed.push_back(mk_write(8'd20, 32'h0080_8080));
        directed.push_back(mk_query(8'h80, 8'h80, 8'h80));
        directed.push_back(mk_query(8'h81, 8'h7f, 8'h80));
        directed.push_back(mk_write(8'd10, UNUSED_WORD));
        directed.push_back(mk_query(8'h80, 8'h80, 8'h80));
        directed.push_back(mk_write(8'd30, 32'hff7f_7f7f));
        directed.push_back(mk_query(8'h7f, 8'h7f, 8'h7f));
        directed.push_back(mk_write(8'd5, 32'h00ff_0000));
        directed.push_back(mk_query(8'hff, 8'h00, 8'h00));
        directed.push_back(mk_write(8'd0, UNUSED_WORD));
        directed.push_back(mk_write(8'd255, UNUSED_WORD));
        directed.push_back(mk_write(8'd20, UNUSED_WORD));
        directed.push_back(mk_write(8'd30, UNUSED_WORD));
        directed.push_back(mk_write(8'd5, UNUSED_WORD));
        directed.push_back(mk_query(8'h55, 8'haa, 8'h55));
        foreach (directed[i]) send_request(directed[i], pick_gap());

        for (int n = 0; n < N_RANDOM; n++) begin
            sender_idle_on = (n < N_RANDOM - N_QUIET_TAIL) && ((n / 40) % 3 != 1);
            sink_idle_on   = sender_idle_on;
            if (n == N_RANDOM / 3) hold_request = 1'b1;
            send_request(random_request(), pick_gap());
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.pending_pens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_pens.size() == 0) begin
            $display("nearest_palette_color_search_tb: done, clean");
        end else begin
            $display("nearest_palette_color_search_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/npc_pkg.sv
rtl/npc_ram.sv
rtl/npc_dist.sv
rtl/nearest_palette_color_search.sv
sim/nearest_palette_color_search_tb.sv
